// ===== sv/rpn_pkg.sv =====
`timescale 1ns / 1ps

package rpn_pkg;

   // Default number of stack entries.
   localparam int RPN_STACK_DEPTH = 128;

   // Width of the Q16.16 operands, and the number of quotient bits of a divide.
   localparam int QW        = 32;
   localparam int DIV_STEPS = 48;

   localparam logic [QW-1:0] EMPTY_TOP = 32'hFFFF_0000;
   localparam logic [QW-1:0] Q_MAX     = 32'h7FFF_FFFF;
   localparam logic [QW-1:0] Q_MIN     = 32'h8000_0000;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_FULL = 3'd1,
      ST_FEW  = 3'd2,
      ST_DIV0 = 3'd3,
      ST_SAT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_DIVFIN
   } state_type;

   typedef struct packed {
      logic          sat;
      logic [QW-1:0] value;
   } sat_type;

   // Clamps a 49-bit signed value to the signed 32-bit range.
   function automatic sat_type sat49(input logic [48:0] v);
      sat_type res;
      res.sat   = !((v[48:31] == 18'h0) || (v[48:31] == 18'h3FFFF));
      res.value = res.sat ? (v[48] ? Q_MIN : Q_MAX) : v[31:0];
      return res;
   endfunction

endpackage

// ===== sv/rpn_stack_evaluator_unit.sv =====
`timescale 1ns / 1ps

// Reverse Polish evaluator on a bounded stack of signed Q16.16 operands.
//
// Commands enter on the req_ channel: a beat is taken at a rising edge with
// start high and busy low. Opcode push places req_operand on the stack; add,
// subtract, multiply and divide replace the two top entries by (deeper op top).
// Every command gives exactly one result beat on the rsp_ channel, marked by
// rsp_strobe for a single cycle: the new top (minus one when empty), the depth
// and a status code. The receiver cannot stall, so a result is never held.
//
// A push, a rejected command or an undefined opcode is answered in the cycle
// after the accepting edge (busy stays low, so pushes can stream every cycle).
// Add and subtract pass through S_EXEC, multiply through S_EXEC and S_MUL (its
// single 32x32 multiplier is registered before the rounding shift), a nonzero
// divide via S_EXEC, S_DIV and S_DIVFIN; its radix-2 restoring divider makes
// one of the 48 quotient bits per cycle. Busy is high while an operation runs.
//
// The stack lives in a memory with one write and one registered read port;
// the top entry is also kept in a register. Synchronous reset empties the
// stack through the entry count alone; the memory itself is not cleared.
module rpn_stack_evaluator_unit
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_operand,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_top_value,
   output logic [7:0]         rsp_depth,
   output logic [2:0]         rsp_status
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // Stack storage and its registered read port.
   logic [QW-1:0] mem [STACK_DEPTH];
   logic [QW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [QW-1:0] mem_wdata;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [QW-1:0]   top_ff, top_in;
   logic [2:0]      opcode_ff, opcode_in;
   status_type      status_ff, status_in;
   logic            strobe_ff, strobe_in;
   logic [63:0]     prod_ff, prod_in;
   logic [31:0]     rem_ff, rem_in;
   logic [47:0]     dq_ff, dq_in;
   logic [31:0]     dvsr_ff, dvsr_in;
   logic            neg_ff, neg_in;
   logic [5:0]      iter_ff, iter_in;

   logic [CW-1:0]   count_m1;
   logic [CW-1:0]   count_m2;
   logic [32:0]     sum;
   logic [33:0]     trial;
   logic [31:0]     mag_b;
   logic [48:0]     wide;
   sat_type         clamp;
   logic [CW+7:0]   depth_ext;

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign rd_addr  = count_m2[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      top_ff    <= top_in;
      opcode_ff <= opcode_in;
      status_ff <= status_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      dq_ff     <= dq_in;
      dvsr_ff   <= dvsr_in;
      neg_ff    <= neg_in;
      iter_ff   <= iter_in;
   end

   // The deeper operand comes from the memory read, the top from top_ff.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      opcode_in = opcode_ff;
      status_in = status_ff;
      strobe_in = 1'b0;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      dvsr_in   = dvsr_ff;
      neg_in    = neg_ff;
      iter_in   = iter_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_wdata = req_operand;
      sum       = '0;
      trial     = '0;
      wide      = '0;
      mag_b     = rd_data_ff[31] ? (32'd0 - rd_data_ff) : rd_data_ff;
      clamp     = sat49(wide);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               opcode_in = req_opcode;
               unique case (req_opcode) inside
                  OP_PUSH: begin
                     strobe_in = 1'b1;
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        top_in    = req_operand;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     if (count_ff < CW'(2)) begin
                        strobe_in = 1'b1;
                        status_in = ST_FEW;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = ST_OK;
                  end
               endcase
            end
         end

         S_EXEC: begin
            mem_waddr = rd_addr;
            unique case (opcode_ff) inside
               OP_ADD, OP_SUB: begin
                  if (opcode_ff == OP_ADD) begin
                     sum = {rd_data_ff[31], rd_data_ff} + {top_ff[31], top_ff};
                  end else begin
                     sum = {rd_data_ff[31], rd_data_ff} - {top_ff[31], top_ff};
                  end
                  wide      = {{16{sum[32]}}, sum};
                  clamp     = sat49(wide);
                  mem_we    = 1'b1;
                  mem_wdata = clamp.value;
                  top_in    = clamp.value;
                  count_in  = count_m1;
                  status_in = clamp.sat ? ST_SAT : ST_OK;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
               OP_MUL: begin
                  prod_in  = 64'($signed(rd_data_ff) * $signed(top_ff));
                  state_in = S_MUL;
               end
               default: begin
                  if (top_ff == '0) begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_data_ff[31] ? Q_MIN : Q_MAX;
                     top_in    = mem_wdata;
                     count_in  = count_m1;
                     status_in = ST_DIV0;
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     rem_in   = '0;
                     dq_in    = {mag_b, 16'h0};
                     dvsr_in  = top_ff[31] ? (32'd0 - top_ff) : top_ff;
                     neg_in   = rd_data_ff[31] ^ top_ff[31];
                     iter_in  = '0;
                     state_in = S_DIV;
                  end
               end
            endcase
         end

         S_MUL: begin
            // Arithmetic shift by 16 rounds toward minus infinity.
            wide      = {prod_ff[63], prod_ff[63:16]};
            clamp     = sat49(wide);
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = clamp.value;
            top_in    = clamp.value;
            count_in  = count_m1;
            status_in = clamp.sat ? ST_SAT : ST_OK;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end

         S_DIV: begin
            // One restoring step: the remainder always stays below the divisor.
            trial = {1'b0, rem_ff, dq_ff[47]} - {2'b00, dvsr_ff};
            if (!trial[33]) begin
               rem_in = trial[31:0];
               dq_in  = {dq_ff[46:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], dq_ff[47]};
               dq_in  = {dq_ff[46:0], 1'b0};
            end
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'(DIV_STEPS - 1)) begin
               state_in = S_DIVFIN;
            end
         end

         S_DIVFIN: begin
            // Truncation toward zero: negate the magnitude quotient if needed.
            wide      = neg_ff ? (49'd0 - {1'b0, dq_ff}) : {1'b0, dq_ff};
            clamp     = sat49(wide);
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = clamp.value;
            top_in    = clamp.value;
            count_in  = count_m1;
            status_in = clamp.sat ? ST_SAT : ST_OK;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign depth_ext     = {8'h0, count_ff};
   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_top_value = (count_ff == '0) ? EMPTY_TOP : top_ff;
   assign rsp_depth     = depth_ext[7:0];
   assign rsp_status    = status_ff;

   // A result beat never coincides with an operation in flight.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // Every accepted command either answers next cycle or starts an operation.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted command neither answered nor started");

   // The entry count never passes the stack size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count beyond stack size");

   // A full report only comes with a full stack.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (count_ff == CW'(STACK_DEPTH)))
      else $error("push-on-full reported with room left");

endmodule
